// ----- rtl/core/smdfx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// smdfx_pkg: shared definitions for the stereo multi-tap delay effect
// Constants, widths, register indexes, rounding helpers and the sine and
// tanh tables, which are built at elaboration with the same integer steps
// as the behavioral definition of the block.
// ----------------------------------------------------------------------------
package smdfx_pkg;

    localparam int unsigned SAMPLE_RATE     = 48000;
    localparam int unsigned SINE_TABLE_BITS = 10;
    localparam int unsigned TANH_TABLE_BITS = 10;
    localparam int unsigned SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int unsigned TANH_N          = 1 << TANH_TABLE_BITS;
    localparam int unsigned RING_AW         = $clog2(SAMPLE_RATE);

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned ACC_W    = 18;
    localparam int unsigned MUL_A_W  = 36;
    localparam int unsigned MUL_B_W  = 18;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned FX_W     = 6;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_FX_ENABLE     = 3'd0;
    localparam logic [2:0] REG_DELAY_AMOUNT  = 3'd1;
    localparam logic [2:0] REG_ECHO_AMOUNT   = 3'd2;
    localparam logic [2:0] REG_REVERB_AMOUNT = 3'd3;
    localparam logic [2:0] REG_FLANGE_AMOUNT = 3'd4;
    localparam logic [2:0] REG_SPACE_AMOUNT  = 3'd5;
    localparam logic [2:0] REG_DUB_AMOUNT    = 3'd6;

    // Effect enable bit positions.
    localparam int unsigned FX_DELAY  = 0;
    localparam int unsigned FX_ECHO   = 1;
    localparam int unsigned FX_REVERB = 2;
    localparam int unsigned FX_FLANGE = 3;
    localparam int unsigned FX_SPACE  = 4;
    localparam int unsigned FX_DUB    = 5;

    // Q15 gains.
    localparam logic signed [MUL_B_W-1:0] K45 = 18'sd14746;
    localparam logic signed [MUL_B_W-1:0] K70 = 18'sd22938;
    localparam logic signed [MUL_B_W-1:0] K40 = 18'sd13107;
    localparam logic signed [MUL_B_W-1:0] K78 = 18'sd25559;

    // Tap distances in samples.
    localparam logic [RING_AW-1:0] TAP_DELAY   = RING_AW'(SAMPLE_RATE * 4 / 10);
    localparam logic [RING_AW-1:0] TAP_ECHO    = RING_AW'(SAMPLE_RATE * 65 / 100);
    localparam logic [RING_AW-1:0] TAP_REV1    = RING_AW'(SAMPLE_RATE * 27 / 1000);
    localparam logic [RING_AW-1:0] TAP_REV2    = RING_AW'(SAMPLE_RATE * 35 / 1000);
    localparam logic [RING_AW-1:0] TAP_REV3    = RING_AW'(SAMPLE_RATE * 41 / 1000);
    localparam logic [RING_AW-1:0] TAP_DUB     = RING_AW'(SAMPLE_RATE * 38 / 100);
    localparam logic [RING_AW-1:0] TAP_SPACE_L = RING_AW'(SAMPLE_RATE * 5 / 1000);
    localparam logic [RING_AW-1:0] TAP_SPACE_R = RING_AW'(SAMPLE_RATE * 15 / 1000);
    localparam logic [RING_AW-1:0] FLANGE_BASE = RING_AW'(120);

    localparam logic [31:0] LFO_INC =
        32'(((64'd7 << 32) + 64'(10 * SAMPLE_RATE)) / 64'(20 * SAMPLE_RATE));

    localparam logic signed [PROD_W-1:0] SAT_HI = 32767;
    localparam logic signed [PROD_W-1:0] SAT_LO = -32768;
    localparam logic [15:0]              AMT_ONE = 16'h8000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q28     = 64'd1 << 28;

    typedef logic [SINE_N-1:0][SAMPLE_W-1:0] sine_rom_t;
    typedef logic [TANH_N-1:0][SAMPLE_W-1:0] tanh_rom_t;

    // Divide by 2^s and round half away from zero.
    function automatic logic signed [PROD_W-1:0] rnd_shift(
        input logic signed [PROD_W-1:0] v,
        input int unsigned              s
    );
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] half;
        logic [PROD_W-1:0] r;
        mag  = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        half = PROD_W'(1) << (s - 1);
        r    = (mag + half) >> s;
        return v[PROD_W-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI)
            r = 16'sh7fff;
        else if (v < SAT_LO)
            r = -16'sh8000;
        else
            r = SAMPLE_W'(v);
        return r;
    endfunction

    function automatic logic [15:0] amt_clamp(input logic [15:0] a);
        return (a > AMT_ONE) ? AMT_ONE : a;
    endfunction

    // Restoring long division, used only while the tables are built.
    function automatic longint unsigned udiv64(
        input longint unsigned a,
        input longint unsigned b
    );
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 64'd0;
        r = 64'd0;
        for (i = 63; i >= 0; i--)
        begin
            r = (r << 1) | ((a >> i) & 64'd1);
            if (r >= b)
            begin
                r = r - b;
                q = q | (64'd1 << i);
            end
        end
        return q;
    endfunction

    function automatic logic [SAMPLE_W-1:0] sine_quarter(
        input longint unsigned j,
        input longint unsigned q
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned sum;
        x   = udiv64(HALF_PI_Q30 * j, q);
        x2  = (x * x) >> 30;
        t   = x;
        sum = x;
        t   = udiv64((t * x2) >> 30, 64'd6);
        sum = sum - t;
        t   = udiv64((t * x2) >> 30, 64'd20);
        sum = sum + t;
        t   = udiv64((t * x2) >> 30, 64'd42);
        sum = sum - t;
        t   = udiv64((t * x2) >> 30, 64'd72);
        sum = sum + t;
        return SAMPLE_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    function automatic sine_rom_t build_sine();
        sine_rom_t             rom;
        int unsigned           q;
        int unsigned           k;
        logic signed [SAMPLE_W-1:0] v;
        q = SINE_N >> 2;
        for (k = 0; k <= q; k++)
            rom[k] = sine_quarter(64'(k), 64'(q));
        for (k = q + 1; k <= 2 * q; k++)
            rom[k] = rom[2 * q - k];
        for (k = 2 * q + 1; k < SINE_N; k++)
        begin
            v      = $signed(rom[k - 2 * q]);
            rom[k] = -v;
        end
        return rom;
    endfunction

    function automatic longint unsigned exp_q28(input longint unsigned y);
        longint unsigned z;
        longint unsigned t;
        longint unsigned sum;
        int unsigned     n;
        z   = y >> 4;
        t   = ONE_Q28;
        sum = ONE_Q28;
        for (n = 1; n <= 6; n++)
        begin
            t   = udiv64((t * z) >> 28, 64'(n));
            sum = sum + t;
        end
        for (n = 0; n < 4; n++)
            sum = (sum * sum) >> 28;
        return sum;
    endfunction

    function automatic tanh_rom_t build_tanh();
        tanh_rom_t       rom;
        int unsigned     k;
        longint unsigned e;
        longint unsigned v;
        for (k = 0; k < TANH_N; k++)
        begin
            e = exp_q28(64'(k) << (30 - TANH_TABLE_BITS));
            v = udiv64((e - ONE_Q28) * 64'd32768 + ((e + ONE_Q28) >> 1), e + ONE_Q28);
            rom[k] = (v > 64'd32767) ? 16'h7fff : SAMPLE_W'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine();
    localparam tanh_rom_t TANH_ROM = build_tanh();

endpackage
`default_nettype wire

// ----- rtl/core/stereo_multitap_delay_fx.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_multitap_delay_fx: stereo multi-tap delay effect
// Six chained effects on two one-second delay rings, run by a sequencer
// around one shared multiplier.
// ----------------------------------------------------------------------------
// After reset the block clears both rings, one address per cycle; in_ready
// stays low meanwhile, while configuration writes are taken at any time.
// With all effects off a frame passes through. Otherwise both channels run
// one after the other through the single multiplier and the single read port
// of each ring, at up to eight ring reads and twelve multiplications per
// channel. A finished frame waits in the output register, and the next frame
// is taken while it waits.
module stereo_multitap_delay_fx (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [smdfx_pkg::SAMPLE_W-1:0] left_in,
    input  wire logic signed [smdfx_pkg::SAMPLE_W-1:0] right_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [smdfx_pkg::SAMPLE_W-1:0]   left_out,
    output logic signed [smdfx_pkg::SAMPLE_W-1:0]   right_out,
    input  wire logic                               cfg_we,
    input  wire logic [2:0]                         cfg_index,
    input  wire logic [smdfx_pkg::CFG_W-1:0]        cfg_data
);
    import smdfx_pkg::*;

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_PHASE, S_SINE, S_FOFF, S_CH_START,
        S_D_RD, S_D_M1, S_D_M2, S_D_WR,
        S_E_RD, S_E_M1, S_E_M2, S_E_ACC,
        S_R_RD1, S_R_RD2, S_R_RD3, S_R_SUM, S_R_M1, S_R_M2, S_R_ACC,
        S_F_RD, S_F_M1, S_F_ADD, S_F_M2, S_F_ACC,
        S_S_RD, S_S_M1, S_S_M2, S_S_ACC,
        S_U_RD, S_U_M1, S_U_M2, S_U_TH, S_U_WR,
        S_CH_END, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [FX_W-1:0]  fx_reg;
    logic [CFG_W-1:0] delay_amt_reg, echo_amt_reg, reverb_amt_reg;
    logic [CFG_W-1:0] flange_amt_reg, space_amt_reg, dub_amt_reg;

    logic               out_valid_reg;
    logic               ch_reg;
    logic [31:0]        phase_reg;
    logic [RING_AW-1:0] w_reg;
    logic [RING_AW-1:0] clr_addr_reg;

    logic signed [SAMPLE_W-1:0] xl_reg, xr_reg, res_l_reg, res_r_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg, right_out_reg;
    logic signed [SAMPLE_W-1:0] sine_reg, l_rd_reg, r_rd_reg;
    logic [SAMPLE_W-1:0]        tanh_reg;
    logic                       tneg_reg;
    logic [RING_AW-1:0]         foff_reg;
    logic signed [ACC_W-1:0]    out_reg;
    logic signed [MUL_A_W-1:0]  hold_reg;
    logic signed [PROD_W-1:0]   mul_reg;

    logic [SAMPLE_W-1:0] left_ring  [SAMPLE_RATE];
    logic [SAMPLE_W-1:0] right_ring [SAMPLE_RATE];

    logic signed [SAMPLE_W-1:0] t_cur, x_cur;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic [RING_AW-1:0]         rd_addr, wr_addr;
    logic                       wr_en, wr_both;
    logic [SAMPLE_W-1:0]        wr_data;
    logic signed [ACC_W-1:0]    th_arg;
    logic [ACC_W-1:0]           th_mag, th_idx_full;
    logic [TANH_TABLE_BITS-1:0] th_idx;
    logic [16:0]                lfo_off;
    logic [24:0]                lfo_scaled;

    function automatic logic [RING_AW-1:0] tap_addr(
        input logic [RING_AW-1:0] w,
        input logic [RING_AW-1:0] d
    );
        logic [RING_AW:0] sum;
        sum = {1'b0, w} + (RING_AW + 1)'(SAMPLE_RATE) - {1'b0, d};
        if (sum >= (RING_AW + 1)'(SAMPLE_RATE))
            sum = sum - (RING_AW + 1)'(SAMPLE_RATE);
        return RING_AW'(sum);
    endfunction

    // First state of the first enabled effect at position 'from' or later, else S_CH_END.
    function automatic state_t next_fx(input logic [2:0] from, input logic [FX_W-1:0] fx);
        state_t s;
        priority if (from <= 3'd0 && fx[FX_DELAY])
            s = S_D_RD;
        else if (from <= 3'd1 && fx[FX_ECHO])
            s = S_E_RD;
        else if (from <= 3'd2 && fx[FX_REVERB])
            s = S_R_RD1;
        else if (from <= 3'd3 && fx[FX_FLANGE])
            s = S_F_RD;
        else if (from <= 3'd4 && fx[FX_SPACE])
            s = S_S_RD;
        else if (from <= 3'd5 && fx[FX_DUB])
            s = S_U_RD;
        else
            s = S_CH_END;
        return s;
    endfunction

    function automatic logic signed [MUL_B_W-1:0] amt_op(input logic [CFG_W-1:0] a);
        return $signed({2'b00, amt_clamp(a)});
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

    assign t_cur = ch_reg ? r_rd_reg : l_rd_reg;
    assign x_cur = ch_reg ? xr_reg : xl_reg;
    assign prod  = mul_a * mul_b;

    assign th_arg      = ACC_W'(PROD_W'(x_cur) + rnd_shift(mul_reg, 30));
    assign th_mag      = th_arg[ACC_W-1] ? ACC_W'(-th_arg) : ACC_W'(th_arg);
    assign th_idx_full = th_mag >> (17 - TANH_TABLE_BITS);
    assign th_idx      = (th_idx_full >= ACC_W'(TANH_N)) ? TANH_TABLE_BITS'(TANH_N - 1)
                                                         : TANH_TABLE_BITS'(th_idx_full);

    assign lfo_off    = 17'd32768 + 17'(sine_reg);
    assign lfo_scaled = 25'(lfo_off) * 25'd140;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg         <= '0;
            delay_amt_reg  <= '0;
            echo_amt_reg   <= '0;
            reverb_amt_reg <= '0;
            flange_amt_reg <= '0;
            space_amt_reg  <= '0;
            dub_amt_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FX_ENABLE:     fx_reg         <= cfg_data[FX_W-1:0];
                REG_DELAY_AMOUNT:  delay_amt_reg  <= cfg_data;
                REG_ECHO_AMOUNT:   echo_amt_reg   <= cfg_data;
                REG_REVERB_AMOUNT: reverb_amt_reg <= cfg_data;
                REG_FLANGE_AMOUNT: flange_amt_reg <= cfg_data;
                REG_SPACE_AMOUNT:  space_amt_reg  <= cfg_data;
                REG_DUB_AMOUNT:    dub_amt_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:      if (clr_addr_reg == RING_AW'(SAMPLE_RATE - 1)) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = (fx_reg == '0) ? S_FIN : S_PHASE;
            S_PHASE:    state_next = S_SINE;
            S_SINE:     state_next = S_FOFF;
            S_FOFF:     state_next = S_CH_START;
            S_CH_START: state_next = next_fx(3'd0, fx_reg);
            S_D_RD:     state_next = S_D_M1;
            S_D_M1:     state_next = S_D_M2;
            S_D_M2:     state_next = S_D_WR;
            S_D_WR:     state_next = next_fx(3'd1, fx_reg);
            S_E_RD:     state_next = S_E_M1;
            S_E_M1:     state_next = S_E_M2;
            S_E_M2:     state_next = S_E_ACC;
            S_E_ACC:    state_next = next_fx(3'd2, fx_reg);
            S_R_RD1:    state_next = S_R_RD2;
            S_R_RD2:    state_next = S_R_RD3;
            S_R_RD3:    state_next = S_R_SUM;
            S_R_SUM:    state_next = S_R_M1;
            S_R_M1:     state_next = S_R_M2;
            S_R_M2:     state_next = S_R_ACC;
            S_R_ACC:    state_next = next_fx(3'd3, fx_reg);
            S_F_RD:     state_next = S_F_M1;
            S_F_M1:     state_next = S_F_ADD;
            S_F_ADD:    state_next = S_F_M2;
            S_F_M2:     state_next = S_F_ACC;
            S_F_ACC:    state_next = next_fx(3'd4, fx_reg);
            S_S_RD:     state_next = S_S_M1;
            S_S_M1:     state_next = S_S_M2;
            S_S_M2:     state_next = S_S_ACC;
            S_S_ACC:    state_next = next_fx(3'd5, fx_reg);
            S_U_RD:     state_next = S_U_M1;
            S_U_M1:     state_next = S_U_M2;
            S_U_M2:     state_next = S_U_TH;
            S_U_TH:     state_next = S_U_WR;
            S_U_WR:     state_next = S_CH_END;
            S_CH_END:   state_next = ch_reg ? S_FIN : S_CH_START;
            S_FIN:      if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_D_M1: begin mul_a = MUL_A_W'(t_cur); mul_b = amt_op(delay_amt_reg); end
            S_E_M1: begin mul_a = MUL_A_W'(t_cur); mul_b = amt_op(echo_amt_reg); end
            S_R_M1: begin mul_a = hold_reg; mul_b = amt_op(reverb_amt_reg); end
            S_F_M1: begin mul_a = MUL_A_W'(t_cur); mul_b = amt_op(flange_amt_reg); end
            S_S_M1: begin mul_a = MUL_A_W'(t_cur); mul_b = amt_op(space_amt_reg); end
            S_U_M1: begin mul_a = MUL_A_W'(t_cur); mul_b = amt_op(dub_amt_reg); end
            S_D_M2: begin mul_a = $signed(mul_reg[MUL_A_W-1:0]); mul_b = K45; end
            S_E_M2: begin mul_a = $signed(mul_reg[MUL_A_W-1:0]); mul_b = K70; end
            S_R_M2: begin mul_a = $signed(mul_reg[MUL_A_W-1:0]); mul_b = K40; end
            S_F_M2: begin mul_a = $signed(mul_reg[MUL_A_W-1:0]); mul_b = K70; end
            S_U_M2: begin mul_a = $signed(mul_reg[MUL_A_W-1:0]); mul_b = K78; end
            S_S_M2:
            begin
                mul_a = MUL_A_W'(out_reg);
                mul_b = $signed(MUL_B_W'(18'd65536 - {2'b00, amt_clamp(space_amt_reg)}));
            end
            default: ;
        endcase
    end

    // Ring read address and write port.
    always_comb
    begin
        rd_addr = w_reg;
        wr_en   = 1'b0;
        wr_both = 1'b0;
        wr_addr = w_reg;
        wr_data = x_cur;
        unique case (state_reg)
            S_D_RD:  rd_addr = tap_addr(w_reg, TAP_DELAY);
            S_E_RD:  rd_addr = tap_addr(w_reg, TAP_ECHO);
            S_R_RD1: rd_addr = tap_addr(w_reg, TAP_REV1);
            S_R_RD2: rd_addr = tap_addr(w_reg, TAP_REV2);
            S_R_RD3: rd_addr = tap_addr(w_reg, TAP_REV3);
            S_F_RD:  rd_addr = tap_addr(w_reg, foff_reg);
            S_S_RD:  rd_addr = tap_addr(w_reg, ch_reg ? TAP_SPACE_R : TAP_SPACE_L);
            S_U_RD:  rd_addr = tap_addr(w_reg, TAP_DUB);
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_both = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            // With delay, echo and dub all off, the dry sample goes in.
            S_CH_START:
                wr_en = !fx_reg[FX_DELAY] && !fx_reg[FX_ECHO] && !fx_reg[FX_DUB];
            S_D_WR:
            begin
                wr_en   = 1'b1;
                wr_data = sat16(PROD_W'(x_cur) + rnd_shift(mul_reg, 30));
            end
            S_U_WR:
            begin
                wr_en   = 1'b1;
                wr_data = tneg_reg ? SAMPLE_W'(-$signed(tanh_reg)) : tanh_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_both || !ch_reg))
            left_ring[wr_addr] <= wr_data;
        if (wr_en && (wr_both || ch_reg))
            right_ring[wr_addr] <= wr_data;
        l_rd_reg <= $signed(left_ring[rd_addr]);
        r_rd_reg <= $signed(right_ring[rd_addr]);
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
            ch_reg        <= 1'b0;
            phase_reg     <= '0;
            w_reg         <= '0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (state_reg == S_PHASE)
            begin
                phase_reg <= phase_reg + LFO_INC;
                ch_reg    <= 1'b0;
            end
            if (state_reg == S_CH_END)
            begin
                ch_reg <= 1'b1;
                if (ch_reg)
                    w_reg <= (w_reg == RING_AW'(SAMPLE_RATE - 1)) ? '0 : w_reg + 1'b1;
            end
            if (state_reg == S_FIN && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    xl_reg    <= left_in;
                    xr_reg    <= right_in;
                    res_l_reg <= left_in;
                    res_r_reg <= right_in;
                end
            end
            S_SINE:     sine_reg <= $signed(SINE_ROM[phase_reg[31 -: SINE_TABLE_BITS]]);
            S_FOFF:     foff_reg <= FLANGE_BASE + RING_AW'(lfo_scaled >> 15);
            S_CH_START: out_reg  <= ACC_W'(x_cur);
            S_D_M1, S_E_M1, S_E_M2, S_R_M1, S_R_M2, S_F_M1, S_F_M2, S_S_M1, S_U_M1:
                mul_reg <= prod;
            S_D_M2, S_U_M2:
            begin
                out_reg <= ACC_W'(sat16(PROD_W'(out_reg) + rnd_shift(mul_reg, 15)));
                mul_reg <= prod;
            end
            S_E_ACC, S_R_ACC:
                out_reg <= ACC_W'(sat16(PROD_W'(out_reg) + rnd_shift(mul_reg, 30)));
            S_R_RD2: hold_reg <= MUL_A_W'(t_cur);
            S_R_RD3, S_R_SUM: hold_reg <= hold_reg + MUL_A_W'(t_cur);
            S_F_ADD: mul_reg <= (PROD_W'(out_reg) <<< 15) + mul_reg;
            // The flange and space results are left unclamped on purpose.
            S_F_ACC: out_reg <= ACC_W'(rnd_shift(mul_reg, 30));
            S_S_M2:
            begin
                hold_reg <= $signed(mul_reg[MUL_A_W-1:0]);
                mul_reg  <= prod;
            end
            S_S_ACC: out_reg <= ACC_W'(rnd_shift(mul_reg + PROD_W'(hold_reg), 16));
            S_U_TH:
            begin
                tanh_reg <= TANH_ROM[th_idx];
                tneg_reg <= th_arg[ACC_W-1];
            end
            S_CH_END:
            begin
                if (ch_reg)
                    res_r_reg <= sat16(PROD_W'(out_reg));
                else
                    res_l_reg <= sat16(PROD_W'(out_reg));
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    left_out_reg  <= res_l_reg;
                    right_out_reg <= res_r_reg;
                end
            end
            default: ;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after a transfer");

    a_index_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg < RING_AW'(SAMPLE_RATE))
        else $error("ring write index out of range");

    a_bypass_holds_index: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && fx_reg == '0) |=> $stable(w_reg) && $stable(phase_reg))
        else $error("state moved on a bypassed frame");

    a_result_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(out_ready))
        else $error("result withdrawn without a transfer");

endmodule
`default_nettype wire
